@@ rtl/qptj_pkg.sv @@
// Shared types, codes and constants for the quaternion pose transform block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package qptj_pkg;

	// input action codes
	localparam logic [1:0] ACT_FWD  = 2'd0;
	localparam logic [1:0] ACT_INV  = 2'd1;
	localparam logic [1:0] ACT_JAC  = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_TX = 3'd0;
	localparam logic [2:0] REG_TY = 3'd1;
	localparam logic [2:0] REG_TZ = 3'd2;
	localparam logic [2:0] REG_QW = 3'd3;
	localparam logic [2:0] REG_QX = 3'd4;
	localparam logic [2:0] REG_QY = 3'd5;
	localparam logic [2:0] REG_QZ = 3'd6;

	localparam logic signed [15:0] QW_RESET = 16'sd32767;

	// Jacobian rows: three translation rows, then four quaternion rows
	localparam logic [2:0] ROW_FIRST_QUAT = 3'd3;
	localparam logic [2:0] ROW_LAST       = 3'd6;

	localparam logic signed [39:0] ONE_Q16 = 40'sd65536;
	localparam logic signed [39:0] OUT_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [39:0] OUT_MIN = -40'sh80_0000_0000;

	localparam int QUEUE_DEPTH = 4;

	// pose as seen by the datapath
	typedef struct packed {
		logic signed [31:0] tx;
		logic signed [31:0] ty;
		logic signed [31:0] tz;
		logic signed [15:0] qw;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic signed [31:0] r00;
		logic signed [31:0] r01;
		logic signed [31:0] r02;
		logic signed [31:0] r10;
		logic signed [31:0] r11;
		logic signed [31:0] r12;
		logic signed [31:0] r20;
		logic signed [31:0] r21;
		logic signed [31:0] r22;
	} pose_t;

	// classified request handed from front to back
	typedef struct packed {
		logic               fwd;
		logic               jac;
		logic signed [32:0] ux;
		logic signed [32:0] uy;
		logic signed [32:0] uz;
	} item_t;

endpackage

@@ rtl/qptj_pose.sv @@
// Pose registers and the rotation matrix built from the quaternion.
// Depends on qptj_pkg.
`timescale 1ns / 1ps

module qptj_pose (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output qptj_pkg::pose_t      pose
);

	localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;

	logic signed [31:0] tx_q, ty_q, tz_q;
	logic signed [15:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [31:0] r00_q, r01_q, r02_q, r10_q, r11_q, r12_q, r20_q, r21_q, r22_q;
	logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
	logic signed [34:0] q00, q01, q02, q10, q11, q12, q20, q21, q22;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_q <= '0;
			ty_q <= '0;
			tz_q <= '0;
			qw_q <= qptj_pkg::QW_RESET;
			qx_q <= '0;
			qy_q <= '0;
			qz_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				qptj_pkg::REG_TX: tx_q <= cfg_data;
				qptj_pkg::REG_TY: ty_q <= cfg_data;
				qptj_pkg::REG_TZ: tz_q <= cfg_data;
				qptj_pkg::REG_QW: qw_q <= cfg_data[15:0];
				qptj_pkg::REG_QX: qx_q <= cfg_data[15:0];
				qptj_pkg::REG_QY: qy_q <= cfg_data[15:0];
				qptj_pkg::REG_QZ: qz_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// quaternion products, Q.30
	assign pxx = 32'(qx_q) * 32'(qx_q);
	assign pyy = 32'(qy_q) * 32'(qy_q);
	assign pzz = 32'(qz_q) * 32'(qz_q);
	assign pxy = 32'(qx_q) * 32'(qy_q);
	assign pxz = 32'(qx_q) * 32'(qz_q);
	assign pyz = 32'(qy_q) * 32'(qz_q);
	assign pwx = 32'(qw_q) * 32'(qx_q);
	assign pwy = 32'(qw_q) * 32'(qy_q);
	assign pwz = 32'(qw_q) * 32'(qz_q);

	// rotation matrix entries, Q.30
	assign q00 = ONE_Q30 - ((35'(pyy) + 35'(pzz)) <<< 1);
	assign q01 = (35'(pxy) - 35'(pwz)) <<< 1;
	assign q02 = (35'(pxz) + 35'(pwy)) <<< 1;
	assign q10 = (35'(pxy) + 35'(pwz)) <<< 1;
	assign q11 = ONE_Q30 - ((35'(pxx) + 35'(pzz)) <<< 1);
	assign q12 = (35'(pyz) - 35'(pwx)) <<< 1;
	assign q20 = (35'(pxz) - 35'(pwy)) <<< 1;
	assign q21 = (35'(pyz) + 35'(pwx)) <<< 1;
	assign q22 = ONE_Q30 - ((35'(pxx) + 35'(pyy)) <<< 1);

	// round half up to Q.26 and hold
	always_ff @(posedge clk) begin
		r00_q <= 32'((q00 + 35'sd8) >>> 4);
		r01_q <= 32'((q01 + 35'sd8) >>> 4);
		r02_q <= 32'((q02 + 35'sd8) >>> 4);
		r10_q <= 32'((q10 + 35'sd8) >>> 4);
		r11_q <= 32'((q11 + 35'sd8) >>> 4);
		r12_q <= 32'((q12 + 35'sd8) >>> 4);
		r20_q <= 32'((q20 + 35'sd8) >>> 4);
		r21_q <= 32'((q21 + 35'sd8) >>> 4);
		r22_q <= 32'((q22 + 35'sd8) >>> 4);
	end

	always_comb begin
		pose.tx  = tx_q;
		pose.ty  = ty_q;
		pose.tz  = tz_q;
		pose.qw  = qw_q;
		pose.qx  = qx_q;
		pose.qy  = qy_q;
		pose.qz  = qz_q;
		pose.r00 = r00_q;
		pose.r01 = r01_q;
		pose.r02 = r02_q;
		pose.r10 = r10_q;
		pose.r11 = r11_q;
		pose.r12 = r12_q;
		pose.r20 = r20_q;
		pose.r21 = r21_q;
		pose.r22 = r22_q;
	end

endmodule

@@ rtl/qptj_front.sv @@
// Front end: accepts requests, drops ACT_NONE requests, forms the vector to rotate.
// Depends on qptj_pkg.
`timescale 1ns / 1ps

module qptj_front (
	input  logic                push,
	input  logic                full,
	input  logic [1:0]          action,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [31:0]  point_z,
	input  qptj_pkg::pose_t     pose,
	output logic                wr_en,
	output qptj_pkg::item_t     wr_item
);

	logic keep;

	// classify the action; forward uses p directly, inverse and Jacobian use p - t
	always_comb begin
		keep        = 1'b1;
		wr_item.fwd = 1'b0;
		wr_item.jac = 1'b0;
		unique case (action)
			qptj_pkg::ACT_FWD:  wr_item.fwd = 1'b1;
			qptj_pkg::ACT_INV:  ;
			qptj_pkg::ACT_JAC:  wr_item.jac = 1'b1;
			default:            keep = 1'b0;
		endcase
		if (wr_item.fwd) begin
			wr_item.ux = 33'(point_x);
			wr_item.uy = 33'(point_y);
			wr_item.uz = 33'(point_z);
		end else begin
			wr_item.ux = 33'(point_x) - 33'(pose.tx);
			wr_item.uy = 33'(point_y) - 33'(pose.ty);
			wr_item.uz = 33'(point_z) - 33'(pose.tz);
		end
	end

	assign wr_en = push && !full && keep;

endmodule

@@ rtl/qptj_queue.sv @@
// Short request queue between front and back ends.
// Depends on qptj_pkg.
`timescale 1ns / 1ps

module qptj_queue #(
	parameter int DEPTH = qptj_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  qptj_pkg::item_t  wr_item,
	input  logic             rd_en,
	output qptj_pkg::item_t  rd_item,
	output logic             nonempty,
	output logic             full
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	qptj_pkg::item_t  mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;

	// store entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wp_q] <= wr_item;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (rd_en) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rd_item  = mem_q[rp_q];
	assign nonempty = (cnt_q != '0);
	assign full     = (cnt_q == CW'(DEPTH));

endmodule

@@ rtl/qptj_back.sv @@
// Back end: rotation pipeline, Jacobian partials and the result row generator.
// Depends on qptj_pkg.
`timescale 1ns / 1ps

module qptj_back (
	input  logic                clk,
	input  logic                arst_n,
	input  qptj_pkg::pose_t     pose,
	input  logic                q_nonempty,
	input  qptj_pkg::item_t     q_item,
	output logic                q_rd,
	input  logic                pop,
	output logic                empty,
	output logic [2:0]          dof_index,
	output logic signed [39:0]  out_x,
	output logic signed [39:0]  out_y,
	output logic signed [39:0]  out_z,
	output logic                last,
	output logic                saturated
);

	logic signed [31:0] rm  [3][3];
	logic signed [31:0] mat [3][3];
	logic signed [32:0] uv  [3];
	logic signed [31:0] tv  [3];
	logic signed [15:0] qv  [4];

	logic               vld_s2, vld_s3, vld_s4, vld_s5;
	logic               fwd_s2;
	logic               jac_s2, jac_s3, jac_s4, jac_s5;
	logic signed [63:0] pr_s2 [3][3];
	logic signed [39:0] m_s3  [3];
	logic signed [39:0] m_s4  [3];
	logic signed [55:0] pq_s4 [4][3];
	logic signed [39:0] m_s5  [3];
	logic signed [39:0] jv_s5 [4][3];
	logic               js_s5 [4];

	logic               gv_q, jac_q;
	logic [2:0]         row_q;
	logic signed [39:0] xf_q [3];
	logic signed [39:0] jr_q [4][3];
	logic               js_q [4];

	logic ld3, ld4, ld5, ld_gen, gen_free;
	logic signed [39:0] m_nx  [3];
	logic signed [39:0] jv_nx [4][3];
	logic               js_nx [4];

	// unpack pose
	always_comb begin
		rm[0][0] = pose.r00; rm[0][1] = pose.r01; rm[0][2] = pose.r02;
		rm[1][0] = pose.r10; rm[1][1] = pose.r11; rm[1][2] = pose.r12;
		rm[2][0] = pose.r20; rm[2][1] = pose.r21; rm[2][2] = pose.r22;
		tv[0] = pose.tx; tv[1] = pose.ty; tv[2] = pose.tz;
		qv[0] = pose.qw; qv[1] = pose.qx; qv[2] = pose.qy; qv[3] = pose.qz;
		uv[0] = q_item.ux; uv[1] = q_item.uy; uv[2] = q_item.uz;
	end

	// forward uses R, inverse and Jacobian use its transpose
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				mat[i][j] = q_item.fwd ? rm[i][j] : rm[j][i];
			end
		end
	end

	// stage loads, back to front
	assign gen_free = !gv_q || (pop && last);
	assign ld_gen   = vld_s5 && gen_free;
	assign ld5      = vld_s4 && (!vld_s5 || ld_gen);
	assign ld4      = vld_s3 && (!vld_s4 || ld5);
	assign ld3      = vld_s2 && (!vld_s3 || ld4);
	assign q_rd     = q_nonempty && (!vld_s2 || ld3);

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (q_rd) vld_s2 <= 1'b1; else if (ld3) vld_s2 <= 1'b0;
			if (ld3) vld_s3 <= 1'b1; else if (ld4) vld_s3 <= 1'b0;
			if (ld4) vld_s4 <= 1'b1; else if (ld5) vld_s4 <= 1'b0;
			if (ld5) vld_s5 <= 1'b1; else if (ld_gen) vld_s5 <= 1'b0;
		end
	end

	// stage 2: matrix times vector products
	always_ff @(posedge clk) begin
		if (q_rd) begin
			fwd_s2 <= q_item.fwd;
			jac_s2 <= q_item.jac;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					pr_s2[i][j] <= 64'(mat[i][j]) * 64'(uv[j]);
				end
			end
		end
	end

	// stage 3: sum rows, add translation for forward, round to Q16.16
	always_comb begin
		logic signed [63:0] acc;
		for (int i = 0; i < 3; i++) begin
			acc = pr_s2[i][0] + pr_s2[i][1] + pr_s2[i][2];
			if (fwd_s2) begin
				acc = acc + (64'(tv[i]) <<< 26);
			end
			m_nx[i] = 40'((acc + 64'sd33554432) >>> 26);
		end
	end

	always_ff @(posedge clk) begin
		if (ld3) begin
			jac_s3 <= jac_s2;
			m_s3   <= m_nx;
		end
	end

	// stage 4: quaternion times model point products
	always_ff @(posedge clk) begin
		if (ld4) begin
			jac_s4 <= jac_s3;
			m_s4   <= m_s3;
			for (int k = 0; k < 4; k++) begin
				for (int i = 0; i < 3; i++) begin
					pq_s4[k][i] <= 56'(qv[k]) * 56'(m_s3[i]);
				end
			end
		end
	end

	// stage 5: quaternion partials, round and clamp
	always_comb begin
		logic signed [59:0] e2 [4][3];
		logic signed [59:0] e4 [4][3];
		logic signed [59:0] a  [4][3];
		logic signed [59:0] rs;
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++) begin
				e2[k][i] = 60'(pq_s4[k][i]) <<< 1;
				e4[k][i] = 60'(pq_s4[k][i]) <<< 2;
			end
		end
		// rows indexed w=0, x=1, y=2, z=3
		a[0][0] = e2[2][2] - e2[3][1];
		a[0][1] = e2[3][0] - e2[1][2];
		a[0][2] = e2[1][1] - e2[2][0];
		a[1][0] = e2[2][1] + e2[3][2];
		a[1][1] = e2[2][0] - e4[1][1] - e2[0][2];
		a[1][2] = e2[3][0] + e2[0][1] - e4[1][2];
		a[2][0] = e2[1][1] - e4[2][0] + e2[0][2];
		a[2][1] = e2[1][0] + e2[3][2];
		a[2][2] = e2[3][1] - e2[0][0] - e4[2][2];
		a[3][0] = e2[1][2] - e2[0][1] - e4[3][0];
		a[3][1] = e2[0][0] - e4[3][1] + e2[2][2];
		a[3][2] = e2[1][0] + e2[2][1];
		for (int k = 0; k < 4; k++) begin
			js_nx[k] = 1'b0;
			for (int i = 0; i < 3; i++) begin
				rs = (a[k][i] + 60'sd16384) >>> 15;
				if (rs > 60'(qptj_pkg::OUT_MAX)) begin
					jv_nx[k][i] = qptj_pkg::OUT_MAX;
					js_nx[k]    = 1'b1;
				end else if (rs < 60'(qptj_pkg::OUT_MIN)) begin
					jv_nx[k][i] = qptj_pkg::OUT_MIN;
					js_nx[k]    = 1'b1;
				end else begin
					jv_nx[k][i] = 40'(rs);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld5) begin
			jac_s5 <= jac_s4;
			m_s5   <= m_s4;
			jv_s5  <= jv_nx;
			js_s5  <= js_nx;
		end
	end

	// row generator: hold one request, step a row per pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gv_q  <= 1'b0;
			row_q <= '0;
		end else if (ld_gen) begin
			gv_q  <= 1'b1;
			row_q <= '0;
		end else if (gv_q && pop) begin
			if (last) begin
				gv_q <= 1'b0;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_gen) begin
			jac_q <= jac_s5;
			xf_q  <= m_s5;
			jr_q  <= jv_s5;
			js_q  <= js_s5;
		end
	end

	// select the current row
	always_comb begin
		logic [1:0] qi;
		qi        = 2'(row_q - qptj_pkg::ROW_FIRST_QUAT);
		dof_index = jac_q ? row_q : '0;
		last      = jac_q ? (row_q == qptj_pkg::ROW_LAST) : 1'b1;
		out_x     = xf_q[0];
		out_y     = xf_q[1];
		out_z     = xf_q[2];
		saturated = 1'b0;
		if (jac_q) begin
			if (row_q < qptj_pkg::ROW_FIRST_QUAT) begin
				out_x = (row_q == 3'd0) ? qptj_pkg::ONE_Q16 : '0;
				out_y = (row_q == 3'd1) ? qptj_pkg::ONE_Q16 : '0;
				out_z = (row_q == 3'd2) ? qptj_pkg::ONE_Q16 : '0;
			end else begin
				out_x     = jr_q[qi][0];
				out_y     = jr_q[qi][1];
				out_z     = jr_q[qi][2];
				saturated = js_q[qi];
			end
		end
	end

	assign empty = !gv_q;

endmodule

@@ rtl/quaternion_pose_transform_jacobian.sv @@
// Quaternion rigid transform and pose Jacobian, top level.
// Input side: push/full; a request is taken when push is high and full is low.
// Action 0 gives R*p+t, action 1 gives R^T*(p-t), action 2 gives seven Jacobian
// rows (three translation rows, then the w, x, y, z partials); action 3 gives
// nothing. Result side: empty/pop; the oldest row sits on the ports while empty
// is low and leaves when pop is high. last marks the final row of a request.
// The user must write pose registers through cfg_we/cfg_index/cfg_data only
// while the block is idle; the block itself does not enforce this. The rotation
// matrix is registered from the quaternion registers and updates in the cycle
// after them. Path: the queue, pipeline stages 2 to 5, then the row generator.
// Throughput: transforms one per cycle while pop is high; a Jacobian holds the
// row generator for its seven rows, one row per pop. When pop stays low the
// generator holds, the pipeline fills, then the queue, and full rises. Reset
// clears the queue, pipeline and generator and loads the identity pose.
// Depends on qptj_pkg, qptj_pose, qptj_front, qptj_queue, qptj_back.
`timescale 1ns / 1ps

module quaternion_pose_transform_jacobian #(
	parameter int QUEUE_DEPTH = qptj_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          action,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [31:0]  point_z,
	output logic                empty,
	input  logic                pop,
	output logic [2:0]          dof_index,
	output logic signed [39:0]  out_x,
	output logic signed [39:0]  out_y,
	output logic signed [39:0]  out_z,
	output logic                last,
	output logic                saturated
);

	qptj_pkg::pose_t pose;
	qptj_pkg::item_t wr_item, rd_item;
	logic            wr_en, rd_en, nonempty;

	qptj_pose u_pose (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pose      (pose)
	);

	qptj_front u_front (
		.push    (push),
		.full    (full),
		.action  (action),
		.point_x (point_x),
		.point_y (point_y),
		.point_z (point_z),
		.pose    (pose),
		.wr_en   (wr_en),
		.wr_item (wr_item)
	);

	qptj_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_item  (wr_item),
		.rd_en    (rd_en),
		.rd_item  (rd_item),
		.nonempty (nonempty),
		.full     (full)
	);

	qptj_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pose       (pose),
		.q_nonempty (nonempty),
		.q_item     (rd_item),
		.q_rd       (rd_en),
		.pop        (pop),
		.empty      (empty),
		.dof_index  (dof_index),
		.out_x      (out_x),
		.out_y      (out_y),
		.out_z      (out_z),
		.last       (last),
		.saturated  (saturated)
	);

endmodule

@@ test/tb_quaternion_pose_transform_jacobian.sv @@
// Self-checking testbench for quaternion_pose_transform_jacobian.
// Predicts every result row in fixed point from the written pose; needs qptj_pkg and the RTL.
`timescale 1ns / 1ps

module tb_quaternion_pose_transform_jacobian;

	typedef struct {
		logic [2:0]  dof;
		logic [39:0] vx;
		logic [39:0] vy;
		logic [39:0] vz;
		logic        fin;
		logic        sat;
	} row_t;

	localparam int STALL_LIMIT = 1000;
	localparam longint SAT_HI = 64'sd549755813887;
	localparam longint SAT_LO = -64'sd549755813888;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;
	logic push;
	logic full;
	logic [1:0] action;
	logic signed [31:0] point_x, point_y, point_z;
	logic empty;
	logic pop;
	logic [2:0] dof_index;
	logic signed [39:0] out_x, out_y, out_z;
	logic last;
	logic saturated;

	// pose copy used for prediction
	logic signed [31:0] pose_t_reg [3];
	logic signed [15:0] pose_q_reg [4];

	row_t expected_rows[$];
	int   errors;
	int   idle_pct;
	int   hold_cycles;
	int   quiet_cycles;

	quaternion_pose_transform_jacobian dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.push(push), .full(full), .action(action),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.empty(empty), .pop(pop), .dof_index(dof_index),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.last(last), .saturated(saturated)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint round_q(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	// clamp three components to 40 bits and queue one row
	function automatic void add_row(logic [2:0] dof, longint v[3], logic fin);
		row_t   r;
		longint c[3];
		r.sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			c[i] = v[i];
			if (c[i] > SAT_HI) begin
				c[i] = SAT_HI;
				r.sat = 1'b1;
			end
			if (c[i] < SAT_LO) begin
				c[i] = SAT_LO;
				r.sat = 1'b1;
			end
		end
		r.dof = dof;
		r.vx = c[0][39:0];
		r.vy = c[1][39:0];
		r.vz = c[2][39:0];
		r.fin = fin;
		expected_rows.insert(expected_rows.size(), r);
	endfunction

	// expected rows of one accepted request
	function automatic void predict_rows(logic [1:0] act, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		longint w, x, y, z;
		longint q[3][3], r[3][3];
		longint p[3], d[3], m[3], v[3], a[4][3], acc;
		if (act == qptj_pkg::ACT_NONE)
			return;
		w = pose_q_reg[0]; x = pose_q_reg[1]; y = pose_q_reg[2]; z = pose_q_reg[3];
		p[0] = px; p[1] = py; p[2] = pz;
		q[0][0] = (longint'(1) << 30) - 2 * (y * y + z * z);
		q[0][1] = 2 * (x * y - w * z);
		q[0][2] = 2 * (x * z + w * y);
		q[1][0] = 2 * (x * y + w * z);
		q[1][1] = (longint'(1) << 30) - 2 * (x * x + z * z);
		q[1][2] = 2 * (y * z - w * x);
		q[2][0] = 2 * (x * z - w * y);
		q[2][1] = 2 * (y * z + w * x);
		q[2][2] = (longint'(1) << 30) - 2 * (x * x + y * y);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				r[i][j] = round_q(q[i][j], 4);
		if (act == qptj_pkg::ACT_FWD) begin
			for (int i = 0; i < 3; i++) begin
				acc = longint'(pose_t_reg[i]) <<< 26;
				for (int j = 0; j < 3; j++)
					acc += r[i][j] * p[j];
				v[i] = round_q(acc, 26);
			end
			add_row(3'd0, v, 1'b1);
			return;
		end
		for (int i = 0; i < 3; i++)
			d[i] = p[i] - longint'(pose_t_reg[i]);
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += r[j][i] * d[j];
			m[i] = round_q(acc, 26);
		end
		if (act == qptj_pkg::ACT_INV) begin
			add_row(3'd0, m, 1'b1);
			return;
		end
		a[0][0] = 2 * y * m[2] - 2 * z * m[1];
		a[0][1] = 2 * z * m[0] - 2 * x * m[2];
		a[0][2] = 2 * x * m[1] - 2 * y * m[0];
		a[1][0] = 2 * y * m[1] + 2 * z * m[2];
		a[1][1] = 2 * y * m[0] - 4 * x * m[1] - 2 * w * m[2];
		a[1][2] = 2 * z * m[0] + 2 * w * m[1] - 4 * x * m[2];
		a[2][0] = 2 * x * m[1] - 4 * y * m[0] + 2 * w * m[2];
		a[2][1] = 2 * x * m[0] + 2 * z * m[2];
		a[2][2] = 2 * z * m[1] - 2 * w * m[0] - 4 * y * m[2];
		a[3][0] = 2 * x * m[2] - 2 * w * m[1] - 4 * z * m[0];
		a[3][1] = 2 * w * m[0] - 4 * z * m[1] + 2 * y * m[2];
		a[3][2] = 2 * x * m[0] + 2 * y * m[1];
		// translation rows are unit vectors
		for (int k = 0; k < 3; k++) begin
			v[0] = 0; v[1] = 0; v[2] = 0;
			v[k] = 65536;
			add_row(3'(k), v, 1'b0);
		end
		for (int k = 0; k < 4; k++) begin
			for (int i = 0; i < 3; i++)
				v[i] = round_q(a[k][i], 15);
			add_row(3'(3 + k), v, k == 3);
		end
	endfunction

	// offer one request, hold it until taken, then predict
	task automatic send_point(logic [1:0] act, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [31:0] pz);
		if ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		push <= 1'b1;
		action <= act;
		point_x <= px;
		point_y <= py;
		point_z <= pz;
		do @(posedge clk); while (full);
		predict_rows(act, px, py, pz);
	endtask

	// drain all expected rows, then let any no-result request clear the pipeline
	task automatic wait_idle();
		push <= 1'b0;
		while (expected_rows.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// write all seven pose registers, one per cycle
	task automatic set_pose(logic signed [31:0] tx, logic signed [31:0] ty,
			logic signed [31:0] tz, logic signed [15:0] qw, logic signed [15:0] qx,
			logic signed [15:0] qy, logic signed [15:0] qz);
		logic [31:0] vals[7];
		vals = '{tx, ty, tz, 32'(qw), 32'(qx), 32'(qy), 32'(qz)};
		for (int i = 0; i < 7; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		pose_t_reg = '{tx, ty, tz};
		pose_q_reg = '{qw, qx, qy, qz};
		repeat (3) @(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return $signed(32'($urandom_range(0, 2 ** 22))) - 32'sd2097152;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] pick_action();
		int n;
		n = $urandom_range(99);
		if (n < 30) return qptj_pkg::ACT_FWD;
		if (n < 55) return qptj_pkg::ACT_INV;
		if (n < 95) return qptj_pkg::ACT_JAC;
		return qptj_pkg::ACT_NONE;
	endfunction

	// extremes of every field, every action, identity and non-unit poses
	task automatic test_directed();
		logic [1:0] acts[4];
		acts = '{qptj_pkg::ACT_FWD, qptj_pkg::ACT_INV, qptj_pkg::ACT_JAC,
			qptj_pkg::ACT_NONE};
		foreach (acts[i]) begin
			send_point(acts[i], 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0);
			send_point(acts[i], 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1);
		end
		send_point(qptj_pkg::ACT_JAC, 32'sd65536, 32'sd131072, -32'sd196608);
		wait_idle();
		// half turn about a tilted axis with extreme translation
		set_pose(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 16'sd0, 16'sd18919,
			16'sd18919, 16'sd18918);
		foreach (acts[i])
			send_point(acts[i], 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
		wait_idle();
		// most negative quaternion parts push Jacobian rows into saturation
		set_pose(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 16'sh8000,
			16'sh8000, 16'sh8000, 16'sh8000);
		send_point(qptj_pkg::ACT_JAC, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(qptj_pkg::ACT_JAC, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		send_point(qptj_pkg::ACT_FWD, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		send_point(qptj_pkg::ACT_INV, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		wait_idle();
		set_pose(32'sd0, 32'sd0, 32'sd0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_point(qptj_pkg::ACT_JAC, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		send_point(qptj_pkg::ACT_FWD, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
		wait_idle();
	endtask

	// random points under a sequence of random and preset poses
	task automatic test_random_poses();
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2)
				idle_pct = 0;
			else
				idle_pct = 34;
			if (ph % 2 == 0)
				set_pose(pick_coord(), pick_coord(), pick_coord(), 16'sd23170,
					16'sd0, -16'sd23170, 16'sd0);
			else
				set_pose($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			for (int n = 0; n < 70; n++)
				send_point(pick_action(), pick_coord(), pick_coord(), pick_coord());
			wait_idle();
		end
		idle_pct = 34;
	endtask

	// hold the result side off while requests keep coming, so full must rise
	task automatic test_full_stall();
		set_pose(32'sd1000, -32'sd1000, 32'sd65536, 16'sd28378, 16'sd8192,
			16'sd8192, 16'sd8192);
		hold_cycles = 200;
		for (int n = 0; n < 30; n++)
			send_point(pick_action(), pick_coord(), pick_coord(), pick_coord());
		wait_idle();
	endtask

	// compare each popped row with the oldest prediction
	initial begin
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				if (expected_rows.size() == 0) begin
					$error("row with no request outstanding: dof %0d", dof_index);
					errors++;
				end else begin
					row_t e;
					e = expected_rows.pop_front();
					if (dof_index !== e.dof) begin
						$error("dof_index expected %0d actual %0d", e.dof, dof_index);
						errors++;
					end
					if (out_x !== e.vx) begin
						$error("out_x expected %h actual %h", e.vx, out_x);
						errors++;
					end
					if (out_y !== e.vy) begin
						$error("out_y expected %h actual %h", e.vy, out_y);
						errors++;
					end
					if (out_z !== e.vz) begin
						$error("out_z expected %h actual %h", e.vz, out_z);
						errors++;
					end
					if (last !== e.fin) begin
						$error("last expected %b actual %b", e.fin, last);
						errors++;
					end
					if (saturated !== e.sat) begin
						$error("saturated expected %b actual %b", e.sat, saturated);
						errors++;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= idle_pct);
			end
		end
	end

	// abort when nothing moves for too long
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("quaternion_pose_transform_jacobian regression: fail");
				$finish;
			end
		end
	end

	initial begin
		errors = 0;
		idle_pct = 34;
		hold_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		push = 1'b0;
		action = qptj_pkg::ACT_FWD;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		pose_t_reg = '{32'sd0, 32'sd0, 32'sd0};
		pose_q_reg = '{qptj_pkg::QW_RESET, 16'sd0, 16'sd0, 16'sd0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_poses();
		test_full_stall();
		wait_idle();
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_rows.size() == 0)
			$display("quaternion_pose_transform_jacobian regression: pass");
		else
			$display("quaternion_pose_transform_jacobian regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
rtl/qptj_pkg.sv
rtl/qptj_pose.sv
rtl/qptj_front.sv
rtl/qptj_queue.sv
rtl/qptj_back.sv
rtl/quaternion_pose_transform_jacobian.sv
test/tb_quaternion_pose_transform_jacobian.sv
